FILE: hw/rtl/spfa_pkg.sv
// Shared types and constants for the stack page frame allocator.
// No dependencies.
package spfa_pkg;

   localparam int PAGE_BITS   = 44;
   localparam int STACK_DEPTH = 256;
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int CSR_ADDR_W  = 1;

   localparam logic [63:0] EXHAUSTED_RAW = 64'h0000_0000_8000_0000;
   localparam logic [PAGE_BITS-1:0] EXHAUSTED_PAGE = EXHAUSTED_RAW[PAGE_BITS-1:0];

   localparam logic [CSR_ADDR_W-1:0] CSR_START_PAGE = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_END_PAGE   = CSR_ADDR_W'(1);

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_ALLOCATED = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_FREED     = 2'd2,
      ST_DROPPED   = 2'd3
   } status_type;

endpackage

FILE: hw/rtl/stack_page_frame_allocator_core.sv
// Top level of the stack page frame allocator: recycle stack, bump counter, result register.
// Depends on spfa_pkg.
// A result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle while the result is not stalled; the top of the recycle
// stack sits in a register and the entry beneath it is prefetched from the stack memory each cycle.
// Reset clears the stack count, the bump counter, the end page and the result valid;
// stack memory contents are not cleared and need no clearing pass.
module stack_page_frame_allocator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [spfa_pkg::PAGE_BITS-1:0]      req_page,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [spfa_pkg::PAGE_BITS-1:0]      rsp_page_res,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_we,
   input  logic [spfa_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [spfa_pkg::PAGE_BITS-1:0]      csr_wdata
);

   logic [spfa_pkg::PAGE_BITS-1:0] stack_mem [spfa_pkg::STACK_DEPTH];

   logic [spfa_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [spfa_pkg::PAGE_BITS-1:0] top_ff, top_in;
   logic [spfa_pkg::PAGE_BITS-1:0] below;
   logic [spfa_pkg::PAGE_BITS-1:0] spill_ff;
   logic [spfa_pkg::PAGE_BITS-1:0] fresh_ff, fresh_in;
   logic [spfa_pkg::PAGE_BITS-1:0] end_ff, end_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [spfa_pkg::PAGE_BITS-1:0] page_res_ff, page_res_in;
   spfa_pkg::status_type           status_ff, status_in;

   logic                           accept;
   logic                           mem_we;
   logic [spfa_pkg::IDX_W-1:0]     mem_waddr;
   logic [spfa_pkg::IDX_W-1:0]     mem_raddr;
   logic [spfa_pkg::PAGE_BITS-1:0] mem_rdata_ff;
   logic                           bypass_ff, bypass_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      count_in     = count_ff;
      top_in       = top_ff;
      fresh_in     = fresh_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      page_res_in  = page_res_ff;
      status_in    = status_ff;
      mem_we       = 1'b0;
      mem_waddr    = spfa_pkg::IDX_W'(count_ff - spfa_pkg::CNT_W'(1));

      if (csr_we) begin
         case (csr_addr)
            spfa_pkg::CSR_START_PAGE: fresh_in = csr_wdata;
            spfa_pkg::CSR_END_PAGE:   end_in   = csr_wdata;
            default: ;
         endcase
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         page_res_in  = '0;
         if (req_mode == spfa_pkg::MODE_ALLOC) begin
            if (count_ff != '0) begin
               page_res_in = top_ff;
               status_in   = spfa_pkg::ST_ALLOCATED;
               count_in    = count_ff - spfa_pkg::CNT_W'(1);
               top_in      = below;
            end else if (fresh_ff < end_ff) begin
               page_res_in = fresh_ff;
               status_in   = spfa_pkg::ST_ALLOCATED;
               fresh_in    = fresh_ff + spfa_pkg::PAGE_BITS'(1);
            end else begin
               page_res_in = spfa_pkg::EXHAUSTED_PAGE;
               status_in   = spfa_pkg::ST_EXHAUSTED;
            end
         end else begin
            if (count_ff < spfa_pkg::CNT_W'(spfa_pkg::STACK_DEPTH)) begin
               status_in = spfa_pkg::ST_FREED;
               count_in  = count_ff + spfa_pkg::CNT_W'(1);
               top_in    = req_page;
               mem_we    = (count_ff != '0);
            end else begin
               status_in = spfa_pkg::ST_DROPPED;
            end
         end
      end

      mem_raddr = spfa_pkg::IDX_W'(count_in - spfa_pkg::CNT_W'(2));
      bypass_in = mem_we && (mem_waddr == mem_raddr);
   end

   // prefetch the entry beneath the next top; forward the spilled top on a collision
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= top_ff;
      end
      mem_rdata_ff <= stack_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         fresh_ff     <= '0;
         end_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         bypass_ff    <= 1'b0;
      end else begin
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
         bypass_ff    <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      spill_ff    <= top_ff;
      page_res_ff <= page_res_in;
      status_ff   <= status_in;
   end

   // the entry beneath the top is the registered read, or the top spilled by the last push
   assign below = bypass_ff ? spill_ff : mem_rdata_ff;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_page_res = page_res_ff;
   assign rsp_status   = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spfa_pkg::CNT_W'(spfa_pkg::STACK_DEPTH))
      else $error("stack count above depth");

   a_beat_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request beat without result beat");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode && count_ff < spfa_pkg::CNT_W'(spfa_pkg::STACK_DEPTH)
      |=> count_ff == $past(count_ff) + spfa_pkg::CNT_W'(1))
      else $error("push did not grow stack");

   a_exhausted_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spfa_pkg::ST_EXHAUSTED
      |-> rsp_page_res == spfa_pkg::EXHAUSTED_PAGE)
      else $error("exhausted beat without marker page");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_page_res))
      else $error("stalled result beat changed");

endmodule
